FILE: sv/aahf_pkg.sv
// Shared types and constants of the ADTS header framer.
`timescale 1ns / 1ps
package aahf_pkg;

	typedef logic [7:0] octet_t;

	// Header length and emission slot numbering: 0..6 header, then held, then current
	localparam int HDR_LEN = 7;
	typedef logic [3:0] slot_idx_t;
	localparam slot_idx_t SLOT_FIRST = 4'd0;
	localparam slot_idx_t SLOT_HDR_LAST = 4'd6;
	localparam slot_idx_t SLOT_HELD = 4'd7;
	localparam slot_idx_t SLOT_CUR = 4'd8;

	// ADTS constants
	localparam octet_t SYNC_BYTE = 8'hFF;
	localparam octet_t HDR_BYTE1 = 8'hF1;
	localparam octet_t NIBBLE_MASK = 8'hF0;
	localparam logic [4:0] FULLNESS_LOW = 5'h1F;
	localparam octet_t HDR_BYTE6 = 8'hFC;
	localparam logic [15:0] MIN_FRAMED_LEN = 16'd7;
	localparam logic [12:0] HDR_LEN13 = 13'd7;
	localparam logic [3:0] MAX_RATE_INDEX = 4'd12;
	localparam logic [3:0] MIN_CHANNELS = 4'd1;
	localparam logic [3:0] MAX_CHANNELS = 4'd7;

	// Configuration register indexes
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_OBJECT_TYPE = 2'd0;
	localparam cfg_idx_t CFG_RATE_INDEX = 2'd1;
	localparam cfg_idx_t CFG_CHANNELS = 2'd2;
	localparam int CFG_DATA_W = 5;

	// Frame phase
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HELD = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef logic [HDR_LEN-1:0][7:0] hdr_t;

	// One emitted byte offered to the output register
	typedef struct packed {
		logic valid;
		octet_t data;
		logic done;
	} slot_t;

endpackage

FILE: sv/aahf_raw_if.sv
// Input channel: raw payload bytes.
`timescale 1ns / 1ps
interface aahf_raw_if;
	logic valid;
	logic ready;
	logic [7:0] payload_byte;
	logic [15:0] payload_length;
	logic end_of_frame;

	modport source (output valid, payload_byte, payload_length, end_of_frame, input ready);
	modport sink (input valid, payload_byte, payload_length, end_of_frame, output ready);
endinterface

FILE: sv/aahf_framed_if.sv
// Output channel: ADTS framed bytes.
`timescale 1ns / 1ps
interface aahf_framed_if;
	logic valid;
	logic ready;
	logic [7:0] framed_byte;
	logic frame_done;

	modport source (output valid, framed_byte, frame_done, input ready);
	modport sink (input valid, framed_byte, frame_done, output ready);
endinterface

FILE: sv/aahf_hdr_gen.sv
// ADTS header byte builder from configuration and payload length.
`timescale 1ns / 1ps
module aahf_hdr_gen (
	input  logic [4:0] object_type,
	input  logic [3:0] rate_index,
	input  logic [3:0] channels,
	input  logic [15:0] payload_length,
	output aahf_pkg::hdr_t hdr
);
	import aahf_pkg::*;

	logic [4:0] prof;
	logic [3:0] sri;
	logic [2:0] ch;
	logic [12:0] flen;

	// Clamp configuration fields
	always_comb begin
		prof = ((object_type > 5'd1) ? object_type : 5'd1) - 5'd1;
		sri = (rate_index > MAX_RATE_INDEX) ? MAX_RATE_INDEX : rate_index;
		if (channels < MIN_CHANNELS) begin
			ch = MIN_CHANNELS[2:0];
		end else if (channels > MAX_CHANNELS) begin
			ch = MAX_CHANNELS[2:0];
		end else begin
			ch = channels[2:0];
		end
		flen = payload_length[12:0] + HDR_LEN13;
	end

	// Pack the seven header bytes; private bit stays zero
	always_comb begin
		hdr[0] = SYNC_BYTE;
		hdr[1] = HDR_BYTE1;
		hdr[2] = {prof[1:0], sri, 1'b0, ch[2]};
		hdr[3] = {ch[1:0], 4'b0000, flen[12:11]};
		hdr[4] = flen[10:3];
		hdr[5] = {flen[2:0], FULLNESS_LOW};
		hdr[6] = HDR_BYTE6;
	end

endmodule

FILE: sv/aahf_intake.sv
// Input stage: phase tracking, first-byte hold and the per-item byte sequencer.
`timescale 1ns / 1ps
module aahf_intake (
	input  logic clk,
	input  logic arst_n,
	aahf_raw_if.sink raw,
	input  aahf_pkg::hdr_t hdr,
	output aahf_pkg::slot_t slot,
	input  logic slot_take
);
	import aahf_pkg::*;

	phase_t phase_q;
	phase_t phase_nxt;
	octet_t held_q;

	logic accept;
	logic framed;
	logic load;
	slot_idx_t start_idx;
	logic has_held;

	logic valid_s1;
	slot_idx_t idx_s1;
	hdr_t hdr_s1;
	octet_t held_s1;
	octet_t byte_s1;
	logic last_s1;
	logic has_held_s1;
	logic step;

	assign accept = raw.valid && raw.ready;
	assign framed = (raw.payload_length >= MIN_FRAMED_LEN) && (held_q == SYNC_BYTE)
		&& ((raw.payload_byte & NIBBLE_MASK) == NIBBLE_MASK);
	assign step = valid_s1 && slot_take;
	assign raw.ready = !valid_s1 || (step && (idx_s1 == SLOT_CUR));

	// Next phase
	always_comb begin
		unique case (phase_q)
			PH_IDLE: phase_nxt = raw.end_of_frame ? PH_IDLE : PH_HELD;
			PH_HELD: phase_nxt = raw.end_of_frame ? PH_IDLE : PH_BODY;
			default: phase_nxt = raw.end_of_frame ? PH_IDLE : PH_BODY;
		endcase
	end

	// What the accepted item emits
	always_comb begin
		unique case (phase_q)
			PH_IDLE: begin
				load = raw.end_of_frame;
				start_idx = SLOT_FIRST;
				has_held = 1'b0;
			end
			PH_HELD: begin
				load = 1'b1;
				start_idx = framed ? SLOT_HELD : SLOT_FIRST;
				has_held = 1'b1;
			end
			default: begin
				load = 1'b1;
				start_idx = SLOT_CUR;
				has_held = 1'b0;
			end
		endcase
	end

	// Phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q <= '0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			if (phase_q == PH_IDLE) begin
				held_q <= raw.payload_byte;
			end
		end
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_s1 <= SLOT_FIRST;
		end else if (accept && load) begin
			valid_s1 <= 1'b1;
			idx_s1 <= start_idx;
		end else if (step) begin
			if (idx_s1 == SLOT_CUR) begin
				valid_s1 <= 1'b0;
			end else if ((idx_s1 == SLOT_HDR_LAST) && !has_held_s1) begin
				idx_s1 <= SLOT_CUR;
			end else begin
				idx_s1 <= idx_s1 + 4'd1;
			end
		end
	end

	// Item payload
	always_ff @(posedge clk) begin
		if (accept && load) begin
			hdr_s1 <= hdr;
			held_s1 <= held_q;
			byte_s1 <= raw.payload_byte;
			last_s1 <= raw.end_of_frame;
			has_held_s1 <= has_held;
		end
	end

	// Byte at the current slot
	always_comb begin
		slot.valid = valid_s1;
		slot.done = last_s1 && (idx_s1 == SLOT_CUR);
		if (idx_s1 == SLOT_CUR) begin
			slot.data = byte_s1;
		end else if (idx_s1 == SLOT_HELD) begin
			slot.data = held_s1;
		end else begin
			slot.data = hdr_s1[idx_s1[2:0]];
		end
	end

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (idx_s1 <= SLOT_CUR))
		else $error("slot index out of range");
	a_hold_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (phase_q == PH_IDLE) && !raw.end_of_frame) |=> (!valid_s1 && (phase_q == PH_HELD)))
		else $error("held first byte started emission");
	a_second_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (phase_q == PH_HELD)) |=> (valid_s1 && ((idx_s1 == SLOT_FIRST) || (idx_s1 == SLOT_HELD))))
		else $error("second byte did not start at header or held slot");
	a_skip_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !has_held_s1) |-> (idx_s1 != SLOT_HELD))
		else $error("held slot visited on an item without a held byte");
`endif

endmodule

FILE: sv/aahf_out_reg.sv
// Output register between the sequencer and the framed channel.
`timescale 1ns / 1ps
module aahf_out_reg (
	input  logic clk,
	input  logic arst_n,
	input  aahf_pkg::slot_t slot,
	output logic slot_take,
	aahf_framed_if.source framed
);
	import aahf_pkg::*;

	logic valid_q;
	octet_t data_q;
	logic done_q;

	assign slot_take = !valid_q || framed.ready;
	assign framed.valid = valid_q;
	assign framed.framed_byte = data_q;
	assign framed.frame_done = done_q;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_take) begin
			valid_q <= slot.valid;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (slot_take && slot.valid) begin
			data_q <= slot.data;
			done_q <= slot.done;
		end
	end

endmodule

FILE: sv/aac_adts_header_framer_unit.sv
// Top level of the ADTS header framer: config registers and stage wiring.
//
//  channel   dir  handshake     payload
//  raw       in   valid/ready   payload_byte[8], payload_length[16], end_of_frame
//  framed    out  valid/ready   framed_byte[8], frame_done
//  cfg       in   cfg_wen       cfg_index[2], cfg_data[5]
//
// One byte is taken per cycle unless the output stalls or the sequencer is busy; a
// frame's first byte gives no output until the second. An item producing 9 bytes
// (header, held byte, current byte), 8 for a one-byte frame, holds the input until its
// current byte is taken; the sequencer emits one byte per cycle when the output takes
// it, body bytes too. Bytes pass the sequencer register, then the output register.
// arst_n clears phase, sequencer and output valid; config returns to 2/3/2.
// A stalled framed.ready holds the output register and backs up into raw.ready.
`timescale 1ns / 1ps
module aac_adts_header_framer_unit (
	input  logic clk,
	input  logic arst_n,
	aahf_raw_if.sink raw,
	aahf_framed_if.source framed,
	input  logic cfg_wen,
	input  aahf_pkg::cfg_idx_t cfg_index,
	input  logic [aahf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import aahf_pkg::*;

	logic [4:0] object_type_q;
	logic [3:0] rate_index_q;
	logic [3:0] channels_q;
	hdr_t hdr;
	slot_t slot;
	logic slot_take;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			object_type_q <= 5'd2;
			rate_index_q <= 4'd3;
			channels_q <= 4'd2;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_OBJECT_TYPE: object_type_q <= cfg_data;
				CFG_RATE_INDEX: rate_index_q <= cfg_data[3:0];
				CFG_CHANNELS: channels_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	aahf_hdr_gen u_hdr_gen (
		.object_type(object_type_q),
		.rate_index(rate_index_q),
		.channels(channels_q),
		.payload_length(raw.payload_length),
		.hdr(hdr)
	);

	aahf_intake u_intake (
		.clk(clk),
		.arst_n(arst_n),
		.raw(raw),
		.hdr(hdr),
		.slot(slot),
		.slot_take(slot_take)
	);

	aahf_out_reg u_out_reg (
		.clk(clk),
		.arst_n(arst_n),
		.slot(slot),
		.slot_take(slot_take),
		.framed(framed)
	);

endmodule

FILE: test/tb.sv
// Self-checking testbench for the ADTS header framer: predicts the framed stream and checks it.
`timescale 1ns / 1ps

import aahf_pkg::*;

// One expected byte of the framed stream
typedef struct packed {
	octet_t data;
	logic done;
} framed_exp_t;

// Mirrors the framer state and holds the framed bytes still to come
class adts_stream_checker;
	logic [4:0] obj_type;
	logic [3:0] sf_index;
	logic [3:0] chan_cfg;
	octet_t held_byte;
	phase_t phase;
	framed_exp_t expected_bytes[$];
	framed_exp_t step_out[$];
	int errors;
	int checked;
	int framed_frames;
	int headered_frames;
	int single_frames;

	function new();
		obj_type = 5'd2;
		sf_index = 4'd3;
		chan_cfg = 4'd2;
		held_byte = '0;
		phase = PH_IDLE;
		errors = 0;
		checked = 0;
		framed_frames = 0;
		headered_frames = 0;
		single_frames = 0;
	endfunction

	function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
		case (idx)
			CFG_OBJECT_TYPE: obj_type = value[4:0];
			CFG_RATE_INDEX: sf_index = value[3:0];
			CFG_CHANNELS: chan_cfg = value[3:0];
			default: ;
		endcase
	endfunction

	function void put_byte(octet_t b);
		step_out.push_back('{data: b, done: 1'b0});
	endfunction

	// 7-byte header from the clamped registers; length wraps to 13 bits
	function void put_header(logic [15:0] plen);
		logic [4:0] prof;
		logic [3:0] sri;
		logic [3:0] ch;
		logic [12:0] flen;
		prof = ((obj_type > 5'd1) ? obj_type : 5'd1) - 5'd1;
		sri = (sf_index > MAX_RATE_INDEX) ? MAX_RATE_INDEX : sf_index;
		if (chan_cfg < MIN_CHANNELS) ch = MIN_CHANNELS;
		else if (chan_cfg > MAX_CHANNELS) ch = MAX_CHANNELS;
		else ch = chan_cfg;
		flen = plen[12:0] + HDR_LEN13;
		put_byte(SYNC_BYTE);
		put_byte(HDR_BYTE1);
		put_byte({prof[1:0], sri, 1'b0, ch[2]});
		put_byte({ch[1:0], 4'b0000, flen[12:11]});
		put_byte(flen[10:3]);
		put_byte({flen[2:0], FULLNESS_LOW});
		put_byte(HDR_BYTE6);
	endfunction

	// Accepted payload item: queue the framed bytes it releases
	function void take_payload(octet_t b, logic [15:0] plen, logic eof);
		logic already;
		step_out.delete();
		case (phase)
			PH_IDLE: begin
				if (eof) begin
					put_header(plen);
					put_byte(b);
					single_frames++;
				end else begin
					held_byte = b;
					phase = PH_HELD;
				end
			end
			PH_HELD: begin
				already = (plen >= MIN_FRAMED_LEN) && (held_byte == SYNC_BYTE) &&
					((b & NIBBLE_MASK) == NIBBLE_MASK);
				if (already) begin
					framed_frames++;
				end else begin
					put_header(plen);
					headered_frames++;
				end
				put_byte(held_byte);
				put_byte(b);
				phase = PH_BODY;
			end
			default: put_byte(b);
		endcase
		if (eof) begin
			if (step_out.size() > 0)
				step_out[step_out.size() - 1].done = 1'b1;
			phase = PH_IDLE;
		end
		foreach (step_out[k])
			expected_bytes.push_back(step_out[k]);
	endfunction

	// Accepted framed item against the oldest expectation
	function void check_framed(octet_t b, logic done);
		framed_exp_t want;
		checked++;
		if (expected_bytes.size() == 0) begin
			$error("framed item %02h done=%0b arrived with nothing expected", b, done);
			errors++;
			return;
		end
		want = expected_bytes.pop_front();
		if (b !== want.data) begin
			$error("framed_byte: expected %02h, got %02h", want.data, b);
			errors++;
		end
		if (done !== want.done) begin
			$error("frame_done: expected %0b, got %0b", want.done, done);
			errors++;
		end
	endfunction
endclass

module tb;
	localparam int CLK_HALF = 4;
	localparam int CYCLE_LIMIT = 600000;
	localparam int NUM_PHASES = 7;
	localparam int PHASE_ITEMS = 45;
	localparam int LONG_HOLD = 120;
	localparam cfg_idx_t CFG_NO_REG = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wen;
	cfg_idx_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	aahf_raw_if raw_ch();
	aahf_framed_if framed_ch();

	adts_stream_checker stream_chk;
	int cycle_count = 0;
	int items_sent = 0;
	int tx_calm = 0;
	int reg_writes = 0;

	aac_adts_header_framer_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.raw(raw_ch),
		.framed(framed_ch),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Idle length: mostly short, a few long
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 3);
		else if (r < 95) return $urandom_range(4, 10);
		else return $urandom_range(15, 40);
	endfunction

	function automatic octet_t rand_byte();
		return octet_t'($urandom);
	endfunction

	// Output side: random stalls, one long hold-off to back the block up
	initial begin : framed_sink
		int stall_left;
		int calm_left;
		bit long_done;
		stall_left = 0;
		calm_left = 0;
		long_done = 1'b0;
		framed_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (framed_ch.valid && framed_ch.ready)
				stream_chk.check_framed(framed_ch.framed_byte, framed_ch.frame_done);
			if (!long_done && stream_chk.checked >= 300) begin
				long_done = 1'b1;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0) begin
				if (calm_left > 0) calm_left--;
				else if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(30, 80);
				else if ($urandom_range(0, 3) == 0) stall_left = pick_idle();
			end
			if (stall_left > 0) begin
				framed_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				framed_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one payload item, with an optional gap ahead of it
	task automatic send_byte(octet_t b, logic [15:0] plen, logic eof);
		int gap;
		gap = 0;
		if (tx_calm > 0) tx_calm--;
		else if ($urandom_range(0, 49) == 0) tx_calm = $urandom_range(30, 80);
		else if ($urandom_range(0, 2) == 0) gap = pick_idle();
		if (gap > 0) begin
			raw_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		raw_ch.valid <= 1'b1;
		raw_ch.payload_byte <= b;
		raw_ch.payload_length <= plen;
		raw_ch.end_of_frame <= eof;
		do @(posedge clk); while (!raw_ch.ready);
		stream_chk.take_payload(b, plen, eof);
		items_sent++;
	endtask

	task automatic send_directed();
		int k;
		// single-byte frame
		send_byte(8'h00, 16'd1, 1'b1);
		// already framed, shortest length that qualifies
		send_byte(SYNC_BYTE, 16'd7, 1'b0);
		send_byte(HDR_BYTE1, 16'd7, 1'b0);
		for (k = 0; k < 5; k++)
			send_byte(octet_t'(8'h33 * k), 16'd7, k == 4);
		// sync byte but second nibble not all ones
		send_byte(SYNC_BYTE, 16'd2, 1'b0);
		send_byte(8'hE0, 16'd2, 1'b1);
		// sync pattern but length below the framed minimum
		send_byte(SYNC_BYTE, 16'd6, 1'b0);
		send_byte(8'hFF, 16'd6, 1'b1);
		// zero length
		send_byte(SYNC_BYTE, 16'd0, 1'b0);
		send_byte(8'hF0, 16'd0, 1'b1);
		// largest length, passed through
		send_byte(SYNC_BYTE, 16'hFFFF, 1'b0);
		send_byte(8'hFF, 16'hFFFF, 1'b0);
		send_byte(8'hAA, 16'hFFFF, 1'b1);
		// header length wraps: largest length, and one that wraps to zero
		send_byte(8'hFF, 16'hFFFF, 1'b1);
		send_byte(8'h80, 16'd8185, 1'b1);
		// length changes between first and second byte
		send_byte(SYNC_BYTE, 16'd3, 1'b0);
		send_byte(8'hF2, 16'd7, 1'b1);
		send_byte(SYNC_BYTE, 16'd7, 1'b0);
		send_byte(8'hF3, 16'd3, 1'b1);
	endtask

	// Mostly well-formed frames, raw or already framed; some noise
	task automatic send_random_frame();
		octet_t body[$];
		logic [15:0] lens[$];
		int kind;
		int n;
		int k;
		logic [15:0] plen;
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			n = $urandom_range(7, 14);
			plen = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(7, 65535)) : 16'(n);
			body.push_back(SYNC_BYTE);
			body.push_back({4'hF, 4'($urandom)});
			for (k = 2; k < n; k++) body.push_back(rand_byte());
			for (k = 0; k < n; k++) lens.push_back(plen);
		end else if (kind < 70) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
			plen = 16'(n);
			if ($urandom_range(0, 2) == 0) begin
				body.push_back(SYNC_BYTE);
				body.push_back({4'($urandom_range(0, 14)), 4'($urandom)});
			end else begin
				body.push_back(rand_byte());
				body.push_back(rand_byte());
			end
			for (k = 2; k < n; k++) body.push_back(rand_byte());
			for (k = 0; k < n; k++) lens.push_back(plen);
		end else if (kind < 82) begin
			n = 1;
			body.push_back(rand_byte());
			lens.push_back(($urandom_range(0, 1) == 0) ? 16'd1 : 16'($urandom));
		end else begin
			n = $urandom_range(1, 10);
			body.push_back(($urandom_range(0, 1) == 0) ? SYNC_BYTE : rand_byte());
			body.push_back(($urandom_range(0, 1) == 0) ? {4'hF, 4'($urandom)} : rand_byte());
			for (k = 2; k < n; k++) body.push_back(rand_byte());
			for (k = 0; k < n; k++) lens.push_back(16'($urandom));
		end
		for (k = 0; k < n; k++)
			send_byte(body[k], lens[k], k == n - 1);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		stream_chk.set_reg(idx, value);
		reg_writes++;
	endtask

	// Register settings per phase, extremes first
	task automatic configure(int ph);
		case (ph)
			1: begin
				write_reg(CFG_OBJECT_TYPE, 5'd0);
				write_reg(CFG_RATE_INDEX, 5'd0);
				write_reg(CFG_CHANNELS, 5'd0);
			end
			2: begin
				write_reg(CFG_OBJECT_TYPE, 5'd31);
				write_reg(CFG_RATE_INDEX, 5'd15);
				write_reg(CFG_CHANNELS, 5'd15);
			end
			3: begin
				write_reg(CFG_OBJECT_TYPE, 5'd1);
				write_reg(CFG_RATE_INDEX, 5'd12);
				write_reg(CFG_CHANNELS, 5'd7);
			end
			4: begin
				write_reg(CFG_OBJECT_TYPE, 5'd2);
				write_reg(CFG_RATE_INDEX, 5'd13);
				write_reg(CFG_CHANNELS, 5'd8);
				write_reg(CFG_NO_REG, 5'($urandom));
			end
			5: begin
				// full data width on the narrow registers too
				write_reg(CFG_OBJECT_TYPE, 5'($urandom));
				write_reg(CFG_RATE_INDEX, 5'($urandom));
				write_reg(CFG_CHANNELS, 5'($urandom));
			end
			default: begin
				write_reg(CFG_OBJECT_TYPE, 5'd3);
				write_reg(CFG_RATE_INDEX, 5'd11);
				write_reg(CFG_CHANNELS, 5'd1);
			end
		endcase
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	// Let every expected byte drain, then cover the pipeline latency
	task automatic wait_idle();
		raw_ch.valid <= 1'b0;
		while (stream_chk.expected_bytes.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Main sequence
	initial begin : stimulus
		int ph;
		int phase_start;
		stream_chk = new();
		arst_n <= 1'b0;
		raw_ch.valid <= 1'b0;
		raw_ch.payload_byte <= '0;
		raw_ch.payload_length <= '0;
		raw_ch.end_of_frame <= 1'b0;
		cfg_wen <= 1'b0;
		cfg_index <= CFG_OBJECT_TYPE;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) configure(ph);
			phase_start = items_sent;
			if (ph == 0) send_directed();
			while (items_sent - phase_start < PHASE_ITEMS) send_random_frame();
			wait_idle();
		end
		repeat (10) @(posedge clk);
		$display("Sent %0d payload items over %0d register settings (%0d register writes).",
			items_sent, NUM_PHASES, reg_writes);
		$display("Frames: %0d passed through, %0d given headers, %0d single-byte; %0d bytes checked.",
			stream_chk.framed_frames, stream_chk.headered_frames, stream_chk.single_frames,
			stream_chk.checked);
		if (stream_chk.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
